### hw/rtl/ascii_integer_parser_top_assert.svh
// assertion macros shared by the parser checker
`ifndef ASCII_INTEGER_PARSER_TOP_ASSERT_SVH
`define ASCII_INTEGER_PARSER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define AIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define AIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/aip_pkg.sv
package aip_pkg;

    // field widths
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned VALUE_W = 64;

    // default accumulator width
    localparam int unsigned VALUE_WIDTH_DEFAULT = 64;

    // target kinds
    typedef enum logic [CMD_W-1:0] {
        KIND_U8   = 3'd0,
        KIND_U16  = 3'd1,
        KIND_U32  = 3'd2,
        KIND_U64  = 3'd3,
        KIND_I8   = 3'd4,
        KIND_I16  = 3'd5,
        KIND_I32  = 3'd6,
        KIND_BOOL = 3'd7
    } kind_t;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // signed target kinds take a sign and are sign-extended
    function automatic logic kind_is_signed(kind_t k);
        return (k == KIND_I8) || (k == KIND_I16) || (k == KIND_I32);
    endfunction

    // largest magnitude allowed for a kind
    function automatic logic [VALUE_W-1:0] kind_limit(kind_t k, logic neg);
        logic [VALUE_W-1:0] lim;
        case (k)
            KIND_U8:   lim = 64'h0000_0000_0000_00ff;
            KIND_U16:  lim = 64'h0000_0000_0000_ffff;
            KIND_U32:  lim = 64'h0000_0000_ffff_ffff;
            KIND_U64:  lim = 64'hffff_ffff_ffff_ffff;
            KIND_I8:   lim = neg ? 64'h0000_0000_0000_0080 : 64'h0000_0000_0000_007f;
            KIND_I16:  lim = neg ? 64'h0000_0000_0000_8000 : 64'h0000_0000_0000_7fff;
            KIND_I32:  lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
            default:   lim = 64'h0000_0000_ffff_ffff;
        endcase
        return lim;
    endfunction

endpackage

### hw/rtl/aip_in_if.sv
interface aip_in_if import aip_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic [CMD_W-1:0]  command;

    modport source (output valid, output character, output command, input ready);
    modport sink   (input valid, input character, input command, output ready);
endinterface

### hw/rtl/aip_out_if.sv
interface aip_out_if import aip_pkg::*;;
    logic               valid;
    logic               ready;
    logic               status;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

### hw/rtl/ascii_integer_parser_top.sv
// the result lands on the output register in the cycle after the terminator transfer
// throughput: one char per cycle when not stalled; a string of n chars gives one result
// per-character work is a times-ten shift-add (hex: times-16 shift) into the state regs
// input stalls only while a result waits on the output register and the sink is not ready
// reset (rst_n, async, active low) clears the string state and empties the output register
module ascii_integer_parser_top import aip_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    aip_in_if.sink    chars,
    aip_out_if.source result
);

    localparam int unsigned WIDE_W = VALUE_WIDTH + 4;

    // string state
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   start_reg, start_next;
    logic [1:0]             nchars_reg, nchars_next;
    logic                   zero_reg, zero_next;
    logic                   hex_reg, hex_next;
    logic                   neg_reg, neg_next;
    logic                   digit_reg, digit_next;
    logic                   err_reg, err_next;
    kind_t                  kind_reg, kind_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               status_reg, status_next;
    logic [VALUE_W-1:0] value_reg, value_next;

    logic               in_xfer;
    kind_t              kind_cur;
    logic [CHAR_W-1:0]  ch;
    logic               dig_ok;
    logic [3:0]         dig_val;
    logic [WIDE_W-1:0]  acc_wide;
    logic [WIDE_W-1:0]  wide_sum;
    logic               acc_ovf;
    logic [VALUE_W-1:0] v64;
    logic               fin_bad;
    logic [VALUE_W-1:0] fin_val;

    // handshake: a waiting result does not block a new character unless the sink stalls
    assign chars.ready   = !out_valid_reg || result.ready;
    assign in_xfer       = chars.valid && chars.ready;
    assign result.valid  = out_valid_reg;
    assign result.status = status_reg;
    assign result.value  = value_reg;

    assign ch       = chars.character;
    assign kind_cur = start_reg ? kind_t'(chars.command) : kind_reg;

    // digit decode, hex letters only in hex mode
    always_comb
    begin
        dig_ok  = 1'b0;
        dig_val = 4'd0;
        if (ch inside {[CHAR_0:CHAR_9]})
        begin
            dig_ok  = 1'b1;
            dig_val = 4'(ch - CHAR_0);
        end
        else if (hex_reg && (ch inside {[CHAR_UA:CHAR_UF]}))
        begin
            dig_ok  = 1'b1;
            dig_val = 4'(ch - CHAR_UA + 8'd10);
        end
        else if (hex_reg && (ch inside {[CHAR_LA:CHAR_LF]}))
        begin
            dig_ok  = 1'b1;
            dig_val = 4'(ch - CHAR_LA + 8'd10);
        end
    end

    // accumulate: times 16 or times 10 plus digit, overflow when upper bits are set
    always_comb
    begin
        acc_wide = WIDE_W'(acc_reg);
        if (hex_reg)
        begin
            wide_sum = (acc_wide << 4) | WIDE_W'(dig_val);
        end
        else
        begin
            wide_sum = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(dig_val);
        end
        acc_ovf = |wide_sum[WIDE_W-1:VALUE_WIDTH];
    end

    // range check and final value at the terminator
    always_comb
    begin
        v64     = VALUE_W'(acc_reg);
        fin_bad = err_reg || !digit_reg || (v64 > kind_limit(kind_cur, neg_reg));
        case (kind_cur)
            KIND_I8, KIND_I16, KIND_I32: fin_val = neg_reg ? (VALUE_W'(0) - v64) : v64;
            KIND_BOOL:                   fin_val = VALUE_W'(v64 != VALUE_W'(0));
            default:                     fin_val = v64;
        endcase
        if (fin_bad)
        begin
            fin_val = VALUE_W'(0);
        end
    end

    // string state next value
    always_comb
    begin
        acc_next    = acc_reg;
        start_next  = start_reg;
        nchars_next = nchars_reg;
        zero_next   = zero_reg;
        hex_next    = hex_reg;
        neg_next    = neg_reg;
        digit_next  = digit_reg;
        err_next    = err_reg;
        kind_next   = kind_reg;
        if (in_xfer)
        begin
            kind_next  = kind_cur;
            start_next = 1'b0;
            if (ch == CHAR_NUL)
            begin
                acc_next    = '0;
                start_next  = 1'b1;
                nchars_next = 2'd0;
                zero_next   = 1'b0;
                hex_next    = 1'b0;
                neg_next    = 1'b0;
                digit_next  = 1'b0;
                err_next    = 1'b0;
            end
            else if (!err_reg)
            begin
                if (start_reg && ((ch == CHAR_MINUS) || (ch == CHAR_PLUS)))
                begin
                    if (kind_is_signed(kind_cur))
                    begin
                        neg_next = (ch == CHAR_MINUS);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if ((nchars_reg == 2'd1) && zero_reg && !hex_reg &&
                         ((ch == CHAR_LX) || (ch == CHAR_UX)))
                begin
                    hex_next    = 1'b1;
                    digit_next  = 1'b0;
                    acc_next    = '0;
                    nchars_next = 2'd2;
                end
                else
                begin
                    if (nchars_reg == 2'd0)
                    begin
                        zero_next = (ch == CHAR_0);
                    end
                    if (nchars_reg != 2'd2)
                    begin
                        nchars_next = nchars_reg + 2'd1;
                    end
                    if (!dig_ok || acc_ovf)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        acc_next   = wide_sum[VALUE_WIDTH-1:0];
                        digit_next = 1'b1;
                    end
                end
            end
        end
    end

    // output register next value
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_xfer && (ch == CHAR_NUL))
        begin
            out_valid_next = 1'b1;
            status_next    = fin_bad ? STATUS_INVALID : STATUS_OK;
            value_next     = fin_val;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            start_reg     <= 1'b1;
            nchars_reg    <= 2'd0;
            zero_reg      <= 1'b0;
            hex_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            digit_reg     <= 1'b0;
            err_reg       <= 1'b0;
            kind_reg      <= KIND_U8;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            start_reg     <= start_next;
            nchars_reg    <= nchars_next;
            zero_reg      <= zero_next;
            hex_reg       <= hex_next;
            neg_reg       <= neg_next;
            digit_reg     <= digit_next;
            err_reg       <= err_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
    end

endmodule

### hw/rtl/aip_checker.sv
`include "ascii_integer_parser_top_assert.svh"

module aip_checker import aip_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [CHAR_W-1:0]  in_character,
    input logic               out_valid,
    input logic               out_ready,
    input logic               out_status,
    input logic [VALUE_W-1:0] out_value
);

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    // a stalled result holds
    `AIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_value), "stalled result changed")

    // failed parse gives zero value
    `AIP_ASSERT_NOW(a_err_zero, out_valid && (out_status == STATUS_INVALID), out_value == '0, "error result with nonzero value")

    // terminator transfer gives a result next cycle
    `AIP_ASSERT_NEXT(a_term_result, in_xfer && (in_character == CHAR_NUL), out_valid, "terminator without result")

    // other characters give no result
    `AIP_ASSERT_NEXT(a_no_spurious, in_xfer && (in_character != CHAR_NUL) && (!out_valid || out_ready), !out_valid, "result without terminator")

    // input never stalls while the output register is empty
    `AIP_ASSERT_NOW(a_ready_empty, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind ascii_integer_parser_top aip_checker u_aip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (chars.valid),
    .in_ready     (chars.ready),
    .in_character (chars.character),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_status   (result.status),
    .out_value    (result.value)
);
